// File: rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, stage payload types and helpers for the segment
// intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int N_ORIENT    = 4;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [CROSS_W-1:0]     t_cross;

    typedef enum logic [1:0] {
        ORI_ZERO = 2'd0,
        ORI_POS  = 2'd1,
        ORI_NEG  = 2'd2
    } t_orient;

    // Stage 1: edge vectors, offsets to the tested points, bounding box hits.
    typedef struct packed {
        logic [DIFF_W-1:0]                a_dx;
        logic [DIFF_W-1:0]                a_dy;
        logic [DIFF_W-1:0]                b_dx;
        logic [DIFF_W-1:0]                b_dy;
        logic [N_ORIENT-1:0][DIFF_W-1:0]  rx;
        logic [N_ORIENT-1:0][DIFF_W-1:0]  ry;
        logic [N_ORIENT-1:0]              in_box;
    } t_prep;

    // Stage 2: the two partial products of each cross product.
    typedef struct packed {
        logic [N_ORIENT-1:0][PROD_W-1:0]  p_l;
        logic [N_ORIENT-1:0][PROD_W-1:0]  p_r;
        logic [N_ORIENT-1:0]              in_box;
    } t_mul;

    // Stage 3: orientation signs.
    typedef struct packed {
        t_orient [N_ORIENT-1:0]           orient;
        logic    [N_ORIENT-1:0]           in_box;
    } t_ori;

    // q inside the inclusive bounding box spanned by p and r
    function automatic logic in_box(input t_coord px, input t_coord py,
                                    input t_coord qx, input t_coord qy,
                                    input t_coord rx, input t_coord ry);
        logic x_ok;
        logic y_ok;
        x_ok = ((qx <= px) || (qx <= rx)) && ((qx >= px) || (qx >= rx));
        y_ok = ((qy <= py) || (qy <= ry)) && ((qy >= py) || (qy >= ry));
        return x_ok && y_ok;
    endfunction

    function automatic t_diff sub(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

endpackage

// File: rtl/core/sit_prep.sv
// ----------------------------------------------------------------------------
// sit_prep
// Stage 1: coordinate differences for the four cross products and the four
// bounding box tests.
// ----------------------------------------------------------------------------
module sit_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sit_pkg::t_coord i_a_start_x,
    input  sit_pkg::t_coord i_a_start_y,
    input  sit_pkg::t_coord i_a_end_x,
    input  sit_pkg::t_coord i_a_end_y,
    input  sit_pkg::t_coord i_b_start_x,
    input  sit_pkg::t_coord i_b_start_y,
    input  sit_pkg::t_coord i_b_end_x,
    input  sit_pkg::t_coord i_b_end_y,
    output logic            o_valid,
    input  logic            i_stall,
    output sit_pkg::t_prep  o_data
);
    import sit_pkg::*;

    logic  r_valid;
    t_prep r_data;
    t_prep n_data;

    always_comb begin
        n_data.a_dx   = sub(i_a_end_x, i_a_start_x);
        n_data.a_dy   = sub(i_a_end_y, i_a_start_y);
        n_data.b_dx   = sub(i_b_end_x, i_b_start_x);
        n_data.b_dy   = sub(i_b_end_y, i_b_start_y);
        // B ends against A, then A ends against B, all taken from the far end
        n_data.rx[0]  = sub(i_b_start_x, i_a_end_x);
        n_data.ry[0]  = sub(i_b_start_y, i_a_end_y);
        n_data.rx[1]  = sub(i_b_end_x, i_a_end_x);
        n_data.ry[1]  = sub(i_b_end_y, i_a_end_y);
        n_data.rx[2]  = sub(i_a_start_x, i_b_end_x);
        n_data.ry[2]  = sub(i_a_start_y, i_b_end_y);
        n_data.rx[3]  = sub(i_a_end_x, i_b_end_x);
        n_data.ry[3]  = sub(i_a_end_y, i_b_end_y);
        n_data.in_box[0] = in_box(i_a_start_x, i_a_start_y, i_b_start_x, i_b_start_y,
                                  i_a_end_x, i_a_end_y);
        n_data.in_box[1] = in_box(i_a_start_x, i_a_start_y, i_b_end_x, i_b_end_y,
                                  i_a_end_x, i_a_end_y);
        n_data.in_box[2] = in_box(i_b_start_x, i_b_start_y, i_a_start_x, i_a_start_y,
                                  i_b_end_x, i_b_end_y);
        n_data.in_box[3] = in_box(i_b_start_x, i_b_start_y, i_a_end_x, i_a_end_y,
                                  i_b_end_x, i_b_end_y);
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/sit_mul.sv
// ----------------------------------------------------------------------------
// sit_mul
// Stage 2: the eight signed products that make up the four cross products.
// ----------------------------------------------------------------------------
module sit_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sit_pkg::t_prep i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sit_pkg::t_mul  o_data
);
    import sit_pkg::*;

    logic r_valid;
    t_mul r_data;
    t_mul n_data;

    always_comb begin
        for (int k = 0; k < N_ORIENT; k++) begin
            // first two use A's edge, last two use B's edge
            if (k < N_ORIENT / 2) begin
                n_data.p_l[k] = t_prod'($signed(i_data.a_dy) * $signed(i_data.rx[k]));
                n_data.p_r[k] = t_prod'($signed(i_data.a_dx) * $signed(i_data.ry[k]));
            end else begin
                n_data.p_l[k] = t_prod'($signed(i_data.b_dy) * $signed(i_data.rx[k]));
                n_data.p_r[k] = t_prod'($signed(i_data.b_dx) * $signed(i_data.ry[k]));
            end
        end
        n_data.in_box = i_data.in_box;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/sit_orient.sv
// ----------------------------------------------------------------------------
// sit_orient
// Stage 3: subtracts the product pairs and reduces each cross product to
// its orientation (collinear, positive, negative).
// ----------------------------------------------------------------------------
module sit_orient (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sit_pkg::t_mul i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sit_pkg::t_ori o_data
);
    import sit_pkg::*;

    logic   r_valid;
    t_ori   r_data;
    t_ori   n_data;
    t_cross xprod [N_ORIENT];

    always_comb begin
        for (int k = 0; k < N_ORIENT; k++) begin
            xprod[k] = t_cross'($signed(i_data.p_l[k])) - t_cross'($signed(i_data.p_r[k]));
            if (xprod[k] == '0) begin
                n_data.orient[k] = ORI_ZERO;
            end else if (xprod[k][CROSS_W-1]) begin
                n_data.orient[k] = ORI_NEG;
            end else begin
                n_data.orient[k] = ORI_POS;
            end
        end
        n_data.in_box = i_data.in_box;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Exact closed-segment intersection test for two 2D segments.
// ----------------------------------------------------------------------------
// Four-stage pipeline that takes one segment pair per cycle while the input
// is not stalled and returns one intersects bit per request, in order.
// Stages: coordinate differences and bounding box compares, 17x17 signed
// multiplies, 35-bit cross product subtract and sign, then the orientation
// decision into the output register. Each stage holds only while it is full
// and the stage after it stalls, so bubbles are squeezed out and requests
// keep entering while a result waits. All arithmetic is exact on the raw
// two's complement coordinates.
module segment_intersection_test_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sit_pkg::t_coord i_a_start_x,
    input  sit_pkg::t_coord i_a_start_y,
    input  sit_pkg::t_coord i_a_end_x,
    input  sit_pkg::t_coord i_a_end_y,
    input  sit_pkg::t_coord i_b_start_x,
    input  sit_pkg::t_coord i_b_start_y,
    input  sit_pkg::t_coord i_b_end_x,
    input  sit_pkg::t_coord i_b_end_y,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_intersects
);
    import sit_pkg::*;

    logic  s1_valid;
    logic  s1_stall;
    t_prep s1_data;
    logic  s2_valid;
    logic  s2_stall;
    t_mul  s2_data;
    logic  s3_valid;
    logic  s3_stall;
    t_ori  s3_data;

    logic  r_valid;
    logic  r_hit;
    logic  n_hit;
    logic  out_stall;

    sit_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (s1_valid),
        .i_stall     (s1_stall),
        .o_data      (s1_data)
    );

    sit_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_stall (s2_stall),
        .o_data  (s2_data)
    );

    sit_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_stall (s2_stall),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_stall (s3_stall),
        .o_data  (s3_data)
    );

    // proper crossing, or a collinear endpoint lying on the other segment
    always_comb begin
        n_hit = (s3_data.orient[0] != s3_data.orient[1] &&
                 s3_data.orient[2] != s3_data.orient[3]);
        for (int k = 0; k < N_ORIENT; k++) begin
            if (s3_data.orient[k] == ORI_ZERO && s3_data.in_box[k]) begin
                n_hit = 1'b1;
            end
        end
    end

    assign out_stall = r_valid && i_stall;
    assign s3_stall  = out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!out_stall) begin
            r_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_stall && s3_valid) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid      = r_valid;
    assign o_intersects = r_hit;

`ifndef SYNTHESIS
    // input backpressure only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (s1_valid && s2_valid && s3_valid && o_valid && i_stall))
        else $error("input stall without a full pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !s3_valid) |=> !o_valid)
        else $error("result repeated after being taken");
`endif

endmodule
